// File: rtl/npcl_pkg.sv
package npcl_pkg;

  localparam int unsigned ENTRIES_DEF = 24;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned IDX_W       = 5;
  // cell ids up to 255 fit this width, so slot indexes are compared at it
  localparam int unsigned IDX_CMP_W   = 8;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 24;

  // 3*255^2 fits in 18 bits, and so does the start value 3*256*256
  localparam int unsigned DIST_W = 18;
  localparam int unsigned SQ_W   = 2 * CHAN_W;
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 256 * 256);

  localparam logic [COLOR_W-1:0] WHITE_RAW   = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] WHITE_FIXED = 24'hFAFEFF;

  localparam logic [CODE_W-1:0]  DEFAULT_CODE_RST  = 8'd15;
  localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 24'hFAFEFF;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_CODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_COLOR = 8'd1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EXACT   = 2'd1,
    OP_CODE    = 2'd2,
    OP_NEAREST = 2'd3
  } op_t;

  // item plus running search result, handed from cell to cell
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [IDX_W-1:0]    idx;
    logic [CODE_W-1:0]   code;
    logic [COLOR_W-1:0]  color;
    logic                found;
    logic [COLOR_W-1:0]  res_color;
    logic [CODE_W-1:0]   res_code;
    logic [DIST_W-1:0]   best;
  } tok_t;

  function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: rtl/npcl_req_if.sv
interface npcl_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [4:0] entry_index;
  logic [7:0] color_code;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, opcode, entry_index, color_code, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, opcode, entry_index, color_code, red_in, green_in, blue_in,
                  output ready);
endinterface

// File: rtl/npcl_rsp_if.sv
interface npcl_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] code_out;
  logic       matched;

  modport source (output valid, red_out, green_out, blue_out, code_out, matched,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, code_out, matched,
                  output ready);
endinterface

// File: rtl/npcl_cfg_if.sv
interface npcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [23:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

// File: rtl/nearest_palette_color_lookup_top.sv
// Channel  Dir  Payload                                            Transfer
// req      in   opcode, entry_index, color_code, red/green/blue_in  valid & ready
// rsp      out  red/green/blue_out, code_out, matched               valid & ready
// cfg      in   reg_index, data                                     valid & ready
//
// One item enters per cycle while rsp does not stall; a query's result passes through
// two stages per slot cell plus the output register, req entering unregistered.
// Loads give no result.
// Reset clears all slots to zero and the defaults to their reset values at once.
// A stall on rsp freezes the whole chain and drops req.ready; cfg is always ready.
module nearest_palette_color_lookup_top #(
  parameter int unsigned ENTRIES = npcl_pkg::ENTRIES_DEF
) (
  input logic      clk,
  input logic      rst,
  npcl_req_if.sink   req,
  npcl_rsp_if.source rsp,
  npcl_cfg_if.sink   cfg
);
  import npcl_pkg::*;

  tok_t               chain [ENTRIES+1];
  tok_t               last;
  logic               en;
  logic [COLOR_W-1:0] req_color;
  logic [CODE_W-1:0]  default_code;
  logic [COLOR_W-1:0] default_color;

  logic               out_valid;
  op_t                out_op;
  logic [CHAN_W-1:0]  red_out, green_out, blue_out;
  logic [CODE_W-1:0]  code_out;
  logic               matched;

  logic [COLOR_W-1:0] found_color;
  logic [CODE_W-1:0]  found_code;

  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;
  assign cfg.ready = 1'b1;

  assign req_color = {req.blue_in, req.green_in, req.red_in};

  always_comb begin
    chain[0].valid     = req.valid;
    chain[0].op        = op_t'(req.opcode);
    chain[0].idx       = req.entry_index;
    chain[0].code      = req.color_code;
    // white is stored slightly off; query colors stay as given
    chain[0].color     = (op_t'(req.opcode) == OP_LOAD && req_color == WHITE_RAW) ?
                         WHITE_FIXED : req_color;
    chain[0].found     = 1'b0;
    chain[0].res_color = '0;
    chain[0].res_code  = '0;
    chain[0].best      = DIST_START;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    npcl_cell #(.CELL_ID(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign last = chain[ENTRIES];

  always_comb begin
    found_color = last.found ? last.res_color : default_color;
    found_code  = last.found ? last.res_code  : default_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_code  <= DEFAULT_CODE_RST;
      default_color <= DEFAULT_COLOR_RST;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_DEFAULT_CODE:  default_code  <= cfg.data[CODE_W-1:0];
        REG_DEFAULT_COLOR: default_color <= cfg.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid && (last.op != OP_LOAD);
      out_op    <= last.op;
      red_out   <= '0;
      green_out <= '0;
      blue_out  <= '0;
      code_out  <= '0;
      matched   <= last.found;
      case (last.op)
        OP_EXACT: code_out <= found_code;
        OP_CODE: begin
          red_out   <= found_color[7:0];
          green_out <= found_color[15:8];
          blue_out  <= found_color[23:16];
        end
        OP_NEAREST: begin
          code_out <= last.res_code;
          matched  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.red_out   = red_out;
  assign rsp.green_out = green_out;
  assign rsp.blue_out  = blue_out;
  assign rsp.code_out  = code_out;
  assign rsp.matched   = matched;

  a_nearest_matched: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_op == OP_NEAREST |-> matched)
    else $error("nearest result without match");

  a_code_query_no_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_op == OP_CODE |-> code_out == '0)
    else $error("code query result carries a code");

  a_color_only_for_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_op != OP_CODE |-> red_out == '0 && green_out == '0 && blue_out == '0)
    else $error("color fields set outside a code query");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    en && last.valid && last.op == OP_LOAD |=> !out_valid)
    else $error("load produced a result");

  a_stall_freezes_chain: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(last))
    else $error("chain moved during stall");

endmodule

// File: rtl/npcl_cell.sv
module npcl_cell #(
  parameter int unsigned CELL_ID = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  npcl_pkg::tok_t tok_in,
  output npcl_pkg::tok_t tok_out
);
  import npcl_pkg::*;

  typedef struct packed {
    tok_t                tok;
    logic [SQ_W-1:0]     sq_r;
    logic [SQ_W-1:0]     sq_g;
    logic [SQ_W-1:0]     sq_b;
    logic                hit_color;
    logic                hit_code;
    logic [COLOR_W-1:0]  slot_color;
    logic [CODE_W-1:0]   slot_code;
  } mid_t;

  logic [COLOR_W-1:0] slot_color;
  logic [CODE_W-1:0]  slot_code;
  mid_t               mid;
  mid_t               mid_next;
  tok_t               tok_next;
  logic               wr;
  logic [CHAN_W-1:0]  d_r, d_g, d_b;
  logic [DIST_W-1:0]  slot_dist;

  assign wr = tok_in.valid && (tok_in.op == OP_LOAD) &&
              ({{(IDX_CMP_W-IDX_W){1'b0}}, tok_in.idx} == IDX_CMP_W'(CELL_ID));

  // first half: per-channel squared differences against the slot as it stands
  always_comb begin
    d_r = absdiff(tok_in.color[7:0],   slot_color[7:0]);
    d_g = absdiff(tok_in.color[15:8],  slot_color[15:8]);
    d_b = absdiff(tok_in.color[23:16], slot_color[23:16]);
    mid_next.tok        = tok_in;
    mid_next.sq_r       = {{CHAN_W{1'b0}}, d_r} * {{CHAN_W{1'b0}}, d_r};
    mid_next.sq_g       = {{CHAN_W{1'b0}}, d_g} * {{CHAN_W{1'b0}}, d_g};
    mid_next.sq_b       = {{CHAN_W{1'b0}}, d_b} * {{CHAN_W{1'b0}}, d_b};
    mid_next.hit_color  = (tok_in.color == slot_color);
    mid_next.hit_code   = (tok_in.code == slot_code);
    mid_next.slot_color = slot_color;
    mid_next.slot_code  = slot_code;
  end

  // second half: fold this slot into the running result
  always_comb begin
    slot_dist = DIST_W'(mid.sq_r) + DIST_W'(mid.sq_g) + DIST_W'(mid.sq_b);
    tok_next = mid.tok;
    case (mid.tok.op)
      OP_EXACT: begin
        if (!mid.tok.found && mid.hit_color) begin
          tok_next.found    = 1'b1;
          tok_next.res_code = mid.slot_code;
        end
      end
      OP_CODE: begin
        if (!mid.tok.found && mid.hit_code) begin
          tok_next.found     = 1'b1;
          tok_next.res_color = mid.slot_color;
        end
      end
      OP_NEAREST: begin
        // strict less-than keeps the lowest slot on a tie
        if (slot_dist < mid.tok.best) begin
          tok_next.best     = slot_dist;
          tok_next.res_code = mid.slot_code;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_color    <= '0;
      slot_code     <= '0;
      mid.tok.valid <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (en) begin
      if (wr) begin
        slot_color <= tok_in.color;
        slot_code  <= tok_in.code;
      end
      mid     <= mid_next;
      tok_out <= tok_next;
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import npcl_pkg::*;

  localparam int NSLOT       = ENTRIES_DEF;
  localparam int LAT         = 2 * NSLOT + 1;
  localparam int TAIL        = LAT + 20;
  localparam int RX_HOLD     = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_SHOWN   = 10;

  localparam logic [COLOR_W-1:0] PURE_WHITE   = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] STORED_WHITE = 24'hFAFEFF;
  localparam logic [CODE_W-1:0]  MISS_CODE_0  = 8'd15;
  localparam logic [COLOR_W-1:0] MISS_COLOR_0 = 24'hFAFEFF;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] code;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pal_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CODE_W-1:0] code;
    logic              hit;
  } pal_rsp_t;

  typedef struct {
    pal_item_t item;
    bit        typed;
    pal_rsp_t  want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  npcl_req_if req_ch ();
  npcl_rsp_if rsp_ch ();
  npcl_cfg_if cfg_ch ();

  nearest_palette_color_lookup_top #(.ENTRIES(NSLOT)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow palette and defaults
  logic [COLOR_W-1:0] shadow_color [NSLOT];
  logic [CODE_W-1:0]  shadow_code  [NSLOT];
  logic [CODE_W-1:0]  miss_code;
  logic [COLOR_W-1:0] miss_color;

  pal_rsp_t           awaited_rsp [$];
  step_row_t          steps [$];
  logic [COLOR_W-1:0] color_pool [8];

  int fail_count  = 0;
  int idle_cycles = 0;
  bit tx_burst    = 1'b0;
  bit rx_burst    = 1'b0;
  bit rx_hold_req = 1'b0;

  function automatic int sq_chan(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
    int d = int'(a) - int'(b);
    return d * d;
  endfunction

  // applies one item to the shadow palette; returns 1 when a result is due
  function automatic bit lookup_palette(input pal_item_t it, output pal_rsp_t res);
    logic [COLOR_W-1:0] qc;
    logic [COLOR_W-1:0] sc;
    logic [COLOR_W-1:0] found;
    int best;
    int dist_sq;
    int pick;
    qc  = {it.blue, it.green, it.red};
    res = '0;
    case (it.op)
      OP_LOAD: begin
        if (it.idx < NSLOT) begin
          shadow_color[it.idx] = (qc == PURE_WHITE) ? STORED_WHITE : qc;
          shadow_code[it.idx]  = it.code;
        end
        return 1'b0;
      end
      OP_EXACT: begin
        res.code = miss_code;
        // walk down so the lowest matching slot is the one kept
        for (int i = NSLOT - 1; i >= 0; i--) begin
          if (shadow_color[i] == qc) begin
            res.code = shadow_code[i];
            res.hit  = 1'b1;
          end
        end
      end
      OP_CODE: begin
        found = miss_color;
        for (int i = NSLOT - 1; i >= 0; i--) begin
          if (shadow_code[i] == it.code) begin
            found   = shadow_color[i];
            res.hit = 1'b1;
          end
        end
        {res.blue, res.green, res.red} = found;
      end
      default: begin
        best = 3 * 256 * 256;
        pick = 0;
        for (int i = 0; i < NSLOT; i++) begin
          sc = shadow_color[i];
          dist_sq = sq_chan(sc[7:0], it.red) + sq_chan(sc[15:8], it.green) +
                    sq_chan(sc[23:16], it.blue);
          if (dist_sq < best) begin
            best = dist_sq;
            pick = i;
          end
        end
        res.code = shadow_code[pick];
        res.hit  = 1'b1;
      end
    endcase
    return 1'b1;
  endfunction

  task automatic send_item(input pal_item_t it, input bit typed, input pal_rsp_t want);
    int gap;
    pal_rsp_t res;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.opcode      <= it.op;
    req_ch.entry_index <= it.idx;
    req_ch.color_code  <= it.code;
    req_ch.red_in      <= it.red;
    req_ch.green_in    <= it.green;
    req_ch.blue_in     <= it.blue;
    req_ch.valid       <= 1'b1;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    if (lookup_palette(it, res)) begin
      awaited_rsp.push_back(typed ? want : res);
    end
  endtask

  // loads leave nothing to wait for, so allow the chain to empty after the last result
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.reg_index <= ri;
    cfg_ch.data      <= val;
    cfg_ch.valid     <= 1'b1;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    if (ri == REG_DEFAULT_CODE) begin
      miss_code = val[CODE_W-1:0];
    end else if (ri == REG_DEFAULT_COLOR) begin
      miss_color = val;
    end
  endtask

  task automatic setup_phase(input logic [CODE_W-1:0] dcode, input logic [COLOR_W-1:0] dcolor,
                             input logic [CFG_IDX_W-1:0] stray_idx);
    drain();
    write_reg(REG_DEFAULT_CODE, CFG_DATA_W'(dcode));
    write_reg(REG_DEFAULT_COLOR, dcolor);
    // unmapped index, must be ignored
    write_reg(stray_idx, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
    color_pool[0] = PURE_WHITE;
    color_pool[1] = STORED_WHITE;
    color_pool[2] = '0;
    for (int i = 3; i < 8; i++) color_pool[i] = COLOR_W'($urandom);
  endtask

  task automatic random_phase(input int n, input bit with_hold, input bit with_pause);
    pal_item_t it;
    pal_rsp_t blank;
    logic [COLOR_W-1:0] col;
    int sel;
    blank = '0;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (with_hold && k == 41) begin
        // back-to-back items against a stalled output
        rx_hold_req = 1'b1;
        tx_burst    = 1'b1;
      end
      if (with_pause && k == n / 2) drain();
      sel = $urandom_range(0, 99);
      it.op = (sel < 30) ? OP_LOAD : (sel < 50) ? OP_EXACT : (sel < 70) ? OP_CODE : OP_NEAREST;
      it.idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(NSLOT, 31))
                                          : IDX_W'($urandom_range(0, NSLOT - 1));
      it.code = ($urandom_range(0, 3) == 0) ? CODE_W'($urandom) : CODE_W'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) col = COLOR_W'($urandom);
      else col = color_pool[$urandom_range(0, 7)];
      {it.blue, it.green, it.red} = col;
      send_item(it, 1'b0, blank);
    end
  endtask

  task automatic put_row(input op_t op, input int idx, input int code,
                         input int r, input int g, input int b, input bit typed = 1'b0,
                         input int er = 0, input int eg = 0, input int eb = 0,
                         input int ec = 0, input bit em = 1'b0);
    step_row_t row;
    row.item.op    = op;
    row.item.idx   = IDX_W'(idx);
    row.item.code  = CODE_W'(code);
    row.item.red   = CHAN_W'(r);
    row.item.green = CHAN_W'(g);
    row.item.blue  = CHAN_W'(b);
    row.typed      = typed;
    row.want.red   = CHAN_W'(er);
    row.want.green = CHAN_W'(eg);
    row.want.blue  = CHAN_W'(eb);
    row.want.code  = CODE_W'(ec);
    row.want.hit   = em;
    steps.push_back(row);
  endtask

  // output side: random stalls, plus one long hold on request
  initial begin : rsp_side
    int n;
    int served;
    served = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (served % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (rx_hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      n = rx_burst ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      served++;
    end
  end

  always @(posedge clk) begin : rsp_check
    pal_rsp_t got;
    pal_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.red   = rsp_ch.red_out;
      got.green = rsp_ch.green_out;
      got.blue  = rsp_ch.blue_out;
      got.code  = rsp_ch.code_out;
      got.hit   = rsp_ch.matched;
      if (awaited_rsp.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("%0t: result with none outstanding: rgb %h %h %h code %h matched %b",
                   $realtime, got.red, got.green, got.blue, got.code, got.hit);
      end else begin
        want = awaited_rsp.pop_front();
        if (got != want) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("%0t: mismatch exp rgb %h %h %h code %h matched %b / got %h %h %h %h %b",
                     $realtime, want.red, want.green, want.blue, want.code, want.hit,
                     got.red, got.green, got.blue, got.code, got.hit);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : main_flow
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= OP_LOAD;
    req_ch.entry_index <= '0;
    req_ch.color_code  <= '0;
    req_ch.red_in      <= '0;
    req_ch.green_in    <= '0;
    req_ch.blue_in     <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.reg_index   <= '0;
    cfg_ch.data        <= '0;
    for (int i = 0; i < NSLOT; i++) begin
      shadow_color[i] = '0;
      shadow_code[i]  = '0;
    end
    miss_code  = MISS_CODE_0;
    miss_color = MISS_COLOR_0;

    // empty palette: every slot black with code 0
    put_row(OP_EXACT,   0, 0,     0,    0,    0,    1, 0,    0,    0,    0,    1);
    put_row(OP_CODE,    0, 0,     0,    0,    0,    1, 0,    0,    0,    0,    1);
    put_row(OP_CODE,    0, 'hFF,  0,    0,    0,    1, 'hFF, 'hFE, 'hFA, 0,    0);
    put_row(OP_EXACT,   0, 0,     1,    2,    3,    1, 0,    0,    0,    15,   0);
    put_row(OP_NEAREST, 0, 0,     'hFF, 'hFF, 'hFF, 1, 0,    0,    0,    0,    1);
    // white load is stored off-white; a pure white query cannot hit it
    put_row(OP_LOAD,    0, 'hAA,  'hFF, 'hFF, 'hFF);
    put_row(OP_EXACT,   0, 0,     'hFF, 'hFF, 'hFF, 1, 0,    0,    0,    15,   0);
    put_row(OP_EXACT,   0, 0,     'hFF, 'hFE, 'hFA, 1, 0,    0,    0,    'hAA, 1);
    put_row(OP_CODE,    0, 'hAA,  0,    0,    0,    1, 'hFF, 'hFE, 'hFA, 0,    1);
    put_row(OP_LOAD,    23, 'hFF, 'h80, 'h7F, 'h01);
    // out-of-range slots leave the palette alone
    put_row(OP_LOAD,    24, 'h55, 1,    1,    1);
    put_row(OP_LOAD,    31, 'h66, 0,    0,    0);
    put_row(OP_CODE,    0, 'h55,  0,    0,    0,    1, 'hFF, 'hFE, 'hFA, 0,    0);
    put_row(OP_CODE,    0, 'h66,  0,    0,    0,    1, 'hFF, 'hFE, 'hFA, 0,    0);
    put_row(OP_CODE,    0, 'hFF,  0,    0,    0,    1, 'h80, 'h7F, 'h01, 0,    1);
    put_row(OP_NEAREST, 0, 0,     'h81, 'h7F, 'h01);
    put_row(OP_LOAD,    1, 'h01,  'h10, 'h10, 'h10);
    // equal distance to slot 1 and slot 2: lower slot wins
    put_row(OP_NEAREST, 0, 0,     'h08, 'h08, 'h08);
    put_row(OP_CODE,    0, 0,     0,    0,    0);
    put_row(OP_LOAD,    2, 'hC3,  0,    0,    0);
    put_row(OP_EXACT,   0, 0,     0,    0,    0);
    put_row(OP_NEAREST, 0, 0,     0,    'hFF, 0);
    put_row(OP_LOAD,    5, 'h5A,  'h55, 'hAA, 'h33);
    put_row(OP_EXACT,   0, 0,     'h55, 'hAA, 'h33);
    put_row(OP_NEAREST, 0, 0,     'hAA, 'h55, 'hCC);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) send_item(steps[i].item, steps[i].typed, steps[i].want);

    setup_phase(8'h00, 24'h000000, 8'd2);
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    setup_phase(8'hFF, 24'hFFFFFF, 8'hFF);
    random_phase(PHASE_ITEMS, 1'b1, 1'b0);
    setup_phase(CODE_W'($urandom), COLOR_W'($urandom), CFG_IDX_W'($urandom_range(2, 254)));
    random_phase(PHASE_ITEMS, 1'b0, 1'b1);
    setup_phase(CODE_W'($urandom), COLOR_W'($urandom), CFG_IDX_W'($urandom_range(2, 254)));
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);

    drain();
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0 && awaited_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
